// ===== sv/sfd_pkg.sv =====
// Shared types, constants and field extraction for the sensor frame deframer.
`default_nettype none

package sfd_pkg;

    // Window and frame layout
    localparam int WINDOW_BYTES = 30;
    localparam int CHK_SPAN     = 26;
    localparam int CHK_POS      = 26;
    localparam int TAIL_POS     = 29;
    localparam int PAY_FIRST    = 2;
    localparam int PAY_LAST     = 25;
    localparam int PAY_BYTES    = PAY_LAST - PAY_FIRST + 1;
    localparam int CNT_W        = $clog2(WINDOW_BYTES + 1);

    // Payload byte positions (relative to frame byte 2)
    localparam int PAY_VOLT_HI  = 18;
    localparam int PAY_VOLT_LO  = 19;
    localparam int PAY_TEMP     = 20;
    localparam int PAY_HUMID    = 21;
    localparam int PAY_SMOKE_HI = 22;
    localparam int PAY_SMOKE_LO = 23;

    // Result word fields
    localparam int IDX_W = 4;
    localparam int VAL_W = 17;

    localparam logic [IDX_W-1:0] FLD_VEL_X   = 4'd0;
    localparam logic [IDX_W-1:0] FLD_GYRO_Z  = 4'd8;
    localparam logic [IDX_W-1:0] FLD_VOLTAGE = 4'd9;
    localparam logic [IDX_W-1:0] FLD_TEMP    = 4'd10;
    localparam logic [IDX_W-1:0] FLD_HUMID   = 4'd11;
    localparam logic [IDX_W-1:0] FLD_SMOKE   = 4'd12;
    localparam logic [IDX_W-1:0] LAST_FIELD  = FLD_SMOKE;

    // Configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 2'd1;
    localparam logic [7:0] HEADER_RESET = 8'h7B;
    localparam logic [7:0] TAIL_RESET   = 8'h7D;

    // Frame queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [WINDOW_BYTES-1:0][7:0] window_t;
    typedef logic [PAY_BYTES-1:0][7:0]    frame_t;

    typedef struct packed {
        logic   valid;
        frame_t data;
    } push_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    // Raw value of one result word taken from the frame payload
    function automatic logic signed [VAL_W-1:0] field_word(frame_t f, logic [IDX_W-1:0] idx);
        logic [$clog2(PAY_BYTES)-1:0] b;
        logic [15:0] pair;
        logic signed [VAL_W-1:0] val;
        b    = '0;
        pair = '0;
        val  = '0;
        case (idx) inside
            [FLD_VEL_X:FLD_GYRO_Z]:
            begin
                b    = {idx, 1'b0};
                pair = {f[b], f[b + 1'b1]};
                val  = {pair[15], pair};
            end
            FLD_VOLTAGE: val = {1'b0, f[PAY_VOLT_HI], f[PAY_VOLT_LO]};
            FLD_TEMP:    val = {9'd0, f[PAY_TEMP]};
            FLD_HUMID:   val = {9'd0, f[PAY_HUMID]};
            FLD_SMOKE:   val = {1'b0, f[PAY_SMOKE_HI], f[PAY_SMOKE_LO]};
            default:     val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== sv/sfd_channels.sv =====
// Valid/ready channel interfaces: received bytes, result words, register writes.
`default_nettype none

interface sfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
    logic                              valid;
    logic                              ready;
    logic [sfd_pkg::IDX_W-1:0]         field_index;
    logic signed [sfd_pkg::VAL_W-1:0]  field_value;
    logic                              last_field;

    modport source (output valid, output field_index, output field_value,
                    output last_field, input ready);
    modport sink (input valid, input field_index, input field_value,
                  input last_field, output ready);
endinterface

interface sfd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sfd_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/sfd_front.sv =====
// Front end: byte window, frame counter, header/tail/checksum test, config registers.
`default_nettype none

module sfd_front (
    input  logic               clk,
    input  logic               rst_n,
    sfd_rx_if.sink             rx,
    sfd_cfg_if.sink            cfg,
    input  sfd_pkg::q_status_t q_status,
    output sfd_pkg::push_t     push
);
    import sfd_pkg::*;

    logic [7:0]       hdr_reg, hdr_next;
    logic [7:0]       tail_reg, tail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    window_t          window_reg;
    window_t          win_next;
    logic [CNT_W-1:0] cnt_sat;
    logic [7:0]       chk;
    logic             frame_ok;
    logic             rx_fire;

    // Take a beat only when the queue can hold a frame
    assign rx.ready  = !q_status.full;
    assign cfg.ready = 1'b1;
    assign rx_fire   = rx.valid && rx.ready;

    // Register writes; unknown indexes are dropped
    always_comb
    begin
        hdr_next  = hdr_reg;
        tail_next = tail_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_HEADER: hdr_next  = cfg.data;
                REG_TAIL:   tail_next = cfg.data;
                default:    ;
            endcase
        end
    end

    // Window after this byte shifts in: entry 0 oldest
    assign win_next = {rx.rx_byte, window_reg[WINDOW_BYTES-1:1]};
    assign cnt_sat  = (cnt_reg < CNT_W'(WINDOW_BYTES)) ? cnt_reg + 1'b1 : cnt_reg;

    // Checksum over the leading bytes
    always_comb
    begin
        chk = '0;
        for (int i = 0; i < CHK_SPAN; i++)
        begin
            chk = chk ^ win_next[i];
        end
    end

    assign frame_ok = (cnt_sat == CNT_W'(WINDOW_BYTES))
                   && (win_next[0] == hdr_reg)
                   && (win_next[TAIL_POS] == tail_reg)
                   && (chk == win_next[CHK_POS]);

    assign push.valid = rx_fire && frame_ok;
    assign push.data  = win_next[PAY_LAST:PAY_FIRST];

    // Count restarts on a good frame
    always_comb
    begin
        cnt_next = cnt_reg;
        if (rx_fire)
        begin
            cnt_next = frame_ok ? '0 : cnt_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg  <= HEADER_RESET;
            tail_reg <= TAIL_RESET;
            cnt_reg  <= '0;
        end
        else
        begin
            hdr_reg  <= hdr_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Window contents only matter once the count is full
    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            window_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sfd_queue.sv =====
// Short frame queue between the front end and the word sequencer.
`default_nettype none

module sfd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  sfd_pkg::push_t     push,
    input  logic               pop,
    output sfd_pkg::q_status_t status,
    output sfd_pkg::frame_t    rd_data
);
    import sfd_pkg::*;

    frame_t               entries_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign status.full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign rd_data          = entries_reg[rd_ptr_reg];

    assign do_push = push.valid && !status.full;
    assign do_pop  = pop && status.not_empty;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sfd_back.sv =====
// Back end: walks a frame through its thirteen result words into the output register.
`default_nettype none

module sfd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sfd_pkg::q_status_t q_status,
    input  sfd_pkg::frame_t    q_data,
    output logic               q_pop,
    sfd_out_if.source          fld
);
    import sfd_pkg::*;

    logic                    active_reg, active_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    frame_t                  frame_reg, frame_next;
    logic                    out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]        out_index_reg, out_index_next;
    logic signed [VAL_W-1:0] out_value_reg, out_value_next;
    logic                    out_last_reg, out_last_next;
    logic                    load;

    // New frame only when the previous one is fully issued
    assign q_pop = q_status.not_empty && !active_reg;
    assign load  = active_reg && (!out_valid_reg || fld.ready);

    always_comb
    begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        frame_next     = frame_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        if (fld.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            frame_next  = q_data;
            active_next = 1'b1;
            idx_next    = '0;
        end

        // Issue the next word of the current frame
        if (load)
        begin
            out_valid_next = 1'b1;
            out_index_next = idx_reg;
            out_value_next = field_word(frame_reg, idx_reg);
            out_last_next  = (idx_reg == LAST_FIELD);
            idx_next       = idx_reg + 1'b1;
            if (idx_reg == LAST_FIELD)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg     <= frame_next;
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign fld.valid       = out_valid_reg;
    assign fld.field_index = out_index_reg;
    assign fld.field_value = out_value_reg;
    assign fld.last_field  = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/sensor_frame_deframer_top.sv =====
// A frame's words go through the queue, the frame register and the output register.
// The frame queue holds 2 frames; the byte input stalls only when it is full, and
// takes one byte per cycle otherwise. A frame's 13 words leave one per cycle while
// the output is ready; the sequencer starts a frame once the last is fully issued.
// Reset: header 0x7B, tail 0x7D, byte count zero, queue and output empty.
// Top level of the sensor frame deframer.
`default_nettype none

module sensor_frame_deframer_top (
    input  logic      clk,
    input  logic      rst_n,
    sfd_rx_if.sink    rx,
    sfd_cfg_if.sink   cfg,
    sfd_out_if.source fld
);
    import sfd_pkg::*;

    push_t     push;
    q_status_t q_status;
    frame_t    q_data;
    logic      q_pop;

    sfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .cfg      (cfg),
        .q_status (q_status),
        .push     (push)
    );

    sfd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (q_pop),
        .status  (q_status),
        .rd_data (q_data)
    );

    sfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .fld      (fld)
    );

    // A detected frame never meets a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push.valid && q_status.full))
        else $error("frame pushed into a full queue");

    // The last mark sits on the smoke word only
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        fld.valid |-> (fld.last_field == (fld.field_index == LAST_FIELD)))
        else $error("last mark on wrong word");

    // Words of a frame follow back to back in order
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        fld.valid && fld.ready && !fld.last_field |=>
            fld.valid && (fld.field_index == $past(fld.field_index) + 4'd1))
        else $error("frame words out of order");

    // A frame is taken only from a nonempty queue
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_status.not_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
